// File: rtl/rsi_pkg.sv
// Package for the ray/sphere intersection unit: payload types, widths and register indexes.
package rsi_pkg;

  // Fixed-point fraction bits of all Q-format fields.
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int MIN_W    = 16;
  localparam int DIST_W   = 31;

  // Internal widths: a and |h| fit in 64 bits, the discriminant in 130.
  localparam int A_W     = 64;
  localparam int ROOT_W  = 65;
  localparam int DISC_W  = 2 * ROOT_W;
  localparam int NUM_W   = ROOT_W + 1;
  localparam int SQRT_STAGES = ROOT_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 4'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 31'd65536;
  localparam logic [MIN_W-1:0]    MIN_DIST_RESET = 16'd1;
  localparam logic [DIST_W-1:0]   DIST_MAX       = {DIST_W{1'b1}};

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
  } rsi_in_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] hit_distance;
    logic              far_root;
  } rsi_out_t;

  // Per-ray values that travel alongside the discriminant.
  typedef struct packed {
    logic           nohit;
    logic           gneg;
    logic [A_W-1:0] a;
    logic [A_W-1:0] hmag;
  } rsi_side_t;

endpackage

// File: rtl/rsi_front.sv
// Front end: dot products, |h|^2 and a*c as split products, and the discriminant.
module rsi_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  rsi_pkg::rsi_in_t                    data_i,
  input  logic [rsi_pkg::RADIUS_W-1:0]        radius_i,
  output logic                                valid_o,
  output logic [rsi_pkg::DISC_W-1:0]          disc_o,
  output rsi_pkg::rsi_side_t                  side_o
);

  localparam int AW = rsi_pkg::A_W;
  localparam int HW = AW + 2;
  localparam int PW = 2 * rsi_pkg::RADIUS_W;
  localparam int QW = 2 * AW;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // Stage 1: nine signed products and r^2.
  logic signed [rsi_pkg::COORD_W-1:0] o_s [3];
  logic signed [rsi_pkg::COORD_W-1:0] d_s [3];
  logic signed [AW-1:0] dd_d [3], oo_d [3], do_d [3];
  logic signed [AW-1:0] dd_q [3], oo_q [3], do_q [3];
  logic [PW-1:0] r2_d, r2_q;

  assign o_s[0] = data_i.origin_x;
  assign o_s[1] = data_i.origin_y;
  assign o_s[2] = data_i.origin_z;
  assign d_s[0] = data_i.dir_x;
  assign d_s[1] = data_i.dir_y;
  assign d_s[2] = data_i.dir_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_d[i] = d_s[i] * d_s[i];
      oo_d[i] = o_s[i] * o_s[i];
      do_d[i] = d_s[i] * o_s[i];
    end
    r2_d = radius_i * radius_i;
  end

  // Stage 2: sums. h is the signed dot product d.o.
  logic [AW-1:0] a2_d, a2_q, o2_d, o2_q;
  logic [HW-1:0] h_d, h_q;
  logic [PW-1:0] r2b_q;

  always_comb begin
    a2_d = AW'($unsigned(dd_q[0])) + AW'($unsigned(dd_q[1])) + AW'($unsigned(dd_q[2]));
    o2_d = AW'($unsigned(oo_q[0])) + AW'($unsigned(oo_q[1])) + AW'($unsigned(oo_q[2]));
    h_d  = {{2{do_q[0][AW-1]}}, do_q[0]} + {{2{do_q[1][AW-1]}}, do_q[1]}
         + {{2{do_q[2][AW-1]}}, do_q[2]};
  end

  // Stage 3: magnitudes and signs of h and c.
  logic [HW-1:0] habs;
  logic [AW-1:0] hmag_d, hmag3_q, cmag_d, cmag_q, a3_q;
  logic          gneg_d, gneg3_q, cneg_d, cneg3_q, azero_d, azero3_q;

  always_comb begin
    habs    = h_q[HW-1] ? (~h_q + HW'(1)) : h_q;
    hmag_d  = habs[AW-1:0];
    gneg_d  = !h_q[HW-1] && (h_q != '0);
    cneg_d  = o2_q < AW'(r2b_q);
    cmag_d  = cneg_d ? (AW'(r2b_q) - o2_q) : (o2_q - AW'(r2b_q));
    azero_d = (a2_q == '0);
  end

  // Stage 4: 32x32 partial products of |h|*|h| and a*|c|.
  logic [AW-1:0] hh00_d, hh01_d, hh11_d, ac00_d, ac01_d, ac10_d, ac11_d;
  logic [AW-1:0] hh00_q, hh01_q, hh11_q, ac00_q, ac01_q, ac10_q, ac11_q;
  logic [AW-1:0] hmag4_q, a4_q;
  logic          gneg4_q, cneg4_q, azero4_q;

  always_comb begin
    hh00_d = hmag3_q[31:0] * hmag3_q[31:0];
    hh01_d = hmag3_q[31:0] * hmag3_q[63:32];
    hh11_d = hmag3_q[63:32] * hmag3_q[63:32];
    ac00_d = a3_q[31:0] * cmag_q[31:0];
    ac01_d = a3_q[31:0] * cmag_q[63:32];
    ac10_d = a3_q[63:32] * cmag_q[31:0];
    ac11_d = a3_q[63:32] * cmag_q[63:32];
  end

  // Stage 5: combine the partial products.
  logic [QW-1:0] h2_d, h2_q, ac_d, ac_q;
  logic [AW-1:0] hmag5_q, a5_q;
  logic          gneg5_q, cneg5_q, azero5_q;

  always_comb begin
    h2_d = QW'(hh00_q) + (QW'(hh01_q) << 33) + (QW'(hh11_q) << 64);
    ac_d = QW'(ac00_q) + (QW'(ac01_q) << 32) + (QW'(ac10_q) << 32) + (QW'(ac11_q) << 64);
  end

  // Stage 6: discriminant h^2 - a*c.
  logic [rsi_pkg::DISC_W-1:0] disc_d, disc_q;
  logic                       nohit_d, nohit_q;
  logic [AW-1:0]              hmag6_q, a6_q;
  logic                       gneg6_q;

  always_comb begin
    if (cneg5_q) begin
      disc_d  = rsi_pkg::DISC_W'(h2_q) + rsi_pkg::DISC_W'(ac_q);
      nohit_d = azero5_q;
    end else begin
      disc_d  = rsi_pkg::DISC_W'(h2_q - ac_q);
      nohit_d = azero5_q || (h2_q < ac_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dd_q     <= dd_d;
      oo_q     <= oo_d;
      do_q     <= do_d;
      r2_q     <= r2_d;
      a2_q     <= a2_d;
      o2_q     <= o2_d;
      h_q      <= h_d;
      r2b_q    <= r2_q;
      hmag3_q  <= hmag_d;
      gneg3_q  <= gneg_d;
      cneg3_q  <= cneg_d;
      cmag_q   <= cmag_d;
      azero3_q <= azero_d;
      a3_q     <= a2_q;
      hh00_q   <= hh00_d;
      hh01_q   <= hh01_d;
      hh11_q   <= hh11_d;
      ac00_q   <= ac00_d;
      ac01_q   <= ac01_d;
      ac10_q   <= ac10_d;
      ac11_q   <= ac11_d;
      hmag4_q  <= hmag3_q;
      a4_q     <= a3_q;
      gneg4_q  <= gneg3_q;
      cneg4_q  <= cneg3_q;
      azero4_q <= azero3_q;
      h2_q     <= h2_d;
      ac_q     <= ac_d;
      hmag5_q  <= hmag4_q;
      a5_q     <= a4_q;
      gneg5_q  <= gneg4_q;
      cneg5_q  <= cneg4_q;
      azero5_q <= azero4_q;
      disc_q   <= disc_d;
      nohit_q  <= nohit_d;
      hmag6_q  <= hmag5_q;
      a6_q     <= a5_q;
      gneg6_q  <= gneg5_q;
    end
  end

  assign valid_o      = v6_q;
  assign disc_o       = disc_q;
  assign side_o.nohit = nohit_q;
  assign side_o.gneg  = gneg6_q;
  assign side_o.a     = a6_q;
  assign side_o.hmag  = hmag6_q;

endmodule

// File: rtl/rsi_sqrt.sv
// Integer square root pipeline, one result bit per stage.
module rsi_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rsi_pkg::DISC_W-1:0]  disc_i,
  input  rsi_pkg::rsi_side_t          side_i,
  output logic                        valid_o,
  output logic [rsi_pkg::ROOT_W-1:0]  root_o,
  output rsi_pkg::rsi_side_t          side_o
);

  localparam int NS = rsi_pkg::SQRT_STAGES;
  localparam int DW = rsi_pkg::DISC_W;

  logic               vld_q [NS];
  logic [DW-1:0]      x_q   [NS];
  logic [DW-1:0]      rt_q  [NS];
  rsi_pkg::rsi_side_t sd_q  [NS];

  logic               vld_in [NS];
  logic [DW-1:0]      x_in   [NS];
  logic [DW-1:0]      rt_in  [NS];
  rsi_pkg::rsi_side_t sd_in  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [DW-1:0] BIT = DW'(1) << (2 * (NS - 1 - k));
    logic [DW-1:0] t, x_d, rt_d;

    if (k == 0) begin : g_first
      assign vld_in[k] = valid_i;
      assign x_in[k]   = disc_i;
      assign rt_in[k]  = '0;
      assign sd_in[k]  = side_i;
    end else begin : g_next
      assign vld_in[k] = vld_q[k-1];
      assign x_in[k]   = x_q[k-1];
      assign rt_in[k]  = rt_q[k-1];
      assign sd_in[k]  = sd_q[k-1];
    end

    always_comb begin
      t = rt_in[k] + BIT;
      if (x_in[k] >= t) begin
        x_d  = x_in[k] - t;
        rt_d = (rt_in[k] >> 1) + BIT;
      end else begin
        x_d  = x_in[k];
        rt_d = rt_in[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]  <= x_d;
        rt_q[k] <= rt_d;
        sd_q[k] <= sd_in[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = rt_q[NS-1][rsi_pkg::ROOT_W-1:0];
  assign side_o  = sd_q[NS-1];

endmodule

// File: rtl/rsi_div.sv
// Two-lane restoring divider: floor(n * 2^FRAC_BITS / a), saturated to the distance range.
module rsi_div #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic                                   nohit_i,
  input  logic [1:0][rsi_pkg::NUM_W-1:0]         num_i,
  input  logic [rsi_pkg::A_W-1:0]                a_i,
  output logic                                   valid_o,
  output logic                                   nohit_o,
  output logic [1:0][rsi_pkg::DIST_W-1:0]        dist_o
);

  localparam int QS = rsi_pkg::DIST_W;
  localparam int NW = rsi_pkg::NUM_W + FRAC_BITS;
  localparam int LW = rsi_pkg::A_W + QS;
  localparam int CW = (NW > LW) ? NW : LW;

  logic                    vld_q [QS+1];
  logic                    nh_q  [QS+1];
  logic [rsi_pkg::A_W-1:0] a_q   [QS];
  logic [1:0][CW-1:0]      rem_q [QS+1];
  logic [1:0][QS-1:0]      quo_q [QS+1];
  logic [1:0]              sat_q [QS+1];

  // Stage 0: scale the numerator and flag quotients that overflow 31 bits.
  logic [1:0][CW-1:0] rem0_d;
  logic [1:0]         sat0_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem0_d[l] = CW'(num_i[l]) << FRAC_BITS;
      sat0_d[l] = rem0_d[l] >= (CW'(a_i) << QS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nh_q[0]  <= nohit_i;
      a_q[0]   <= a_i;
      rem_q[0] <= rem0_d;
      quo_q[0] <= '0;
      sat_q[0] <= sat0_d;
    end
  end

  // Stage j settles quotient bit QS-j.
  for (genvar j = 1; j <= QS; j++) begin : g_stage
    localparam int QB = QS - j;
    logic [CW-1:0]      den;
    logic [1:0][CW-1:0] rem_d;
    logic [1:0][QS-1:0] quo_d;

    always_comb begin
      den = CW'(a_q[j-1]) << QB;
      for (int l = 0; l < 2; l++) begin
        rem_d[l] = rem_q[j-1][l];
        quo_d[l] = quo_q[j-1][l];
        if (rem_q[j-1][l] >= den) begin
          rem_d[l]     = rem_q[j-1][l] - den;
          quo_d[l][QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nh_q[j]  <= nh_q[j-1];
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        sat_q[j] <= sat_q[j-1];
      end
    end

    if (j < QS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[j] <= a_q[j-1];
        end
      end
    end
  end

  assign valid_o = vld_q[QS];
  assign nohit_o = nh_q[QS];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dist_o[l] = sat_q[QS][l] ? rsi_pkg::DIST_MAX : quo_q[QS][l];
    end
  end

endmodule

// File: rtl/ray_sphere_intersect_unit.sv
// Top level of the ray/sphere intersection unit.
//
// One ray (origin and direction, signed Q16.16, sphere at the origin) enters on the
// in_valid_i/in_ready_o channel; one result (hit, hit_distance, far_root) leaves on
// the out_valid_o/out_ready_i channel for every ray, in order.
// The radius and the minimum distance are written through the cfg channel, which
// is always ready; write them only while no ray is in flight.
// The unit takes one ray per cycle while in_ready_o is high. On its way to the
// output a ray passes the front-end stages for the products and the discriminant,
// 65 square-root stages (one root bit each), a register forming the root numerators,
// 32 divider stages (scaling, then one quotient bit each) and the output buffer.
// The whole pipeline advances together; a two-entry output buffer holds finished
// results. While the receiver stalls, rays are still accepted until the buffer is
// full, and then in_ready_o drops until a result is taken. Nothing is lost or
// repeated.
// Reset clears all valid bits and the buffer and restores radius 1.0 and minimum
// distance 1 LSB.
module ray_sphere_intersect_unit #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rsi_pkg::rsi_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rsi_pkg::rsi_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int NW = rsi_pkg::NUM_W;

  // Configuration registers.
  logic [rsi_pkg::RADIUS_W-1:0] radius_q;
  logic [rsi_pkg::MIN_W-1:0]    min_dist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= rsi_pkg::RADIUS_RESET;
      min_dist_q <= rsi_pkg::MIN_DIST_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rsi_pkg::REG_SPHERE_RADIUS: radius_q   <= cfg_data_i[rsi_pkg::RADIUS_W-1:0];
        rsi_pkg::REG_MIN_DISTANCE:  min_dist_q <= cfg_data_i[rsi_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Output buffer state decides whether the pipeline moves.
  logic [1:0] cnt_q, cnt_d;
  logic       en;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  logic                       fr_valid;
  logic [rsi_pkg::DISC_W-1:0] fr_disc;
  rsi_pkg::rsi_side_t         fr_side;

  rsi_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .data_i   (in_data_i),
    .radius_i (radius_q),
    .valid_o  (fr_valid),
    .disc_o   (fr_disc),
    .side_o   (fr_side)
  );

  logic                       sq_valid;
  logic [rsi_pkg::ROOT_W-1:0] sq_root;
  rsi_pkg::rsi_side_t         sq_side;

  rsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .disc_i  (fr_disc),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Root numerators: near = -h - s, far = -h + s; non-positive ones become zero.
  logic [NW-1:0]           hm, sr;
  logic [1:0][NW-1:0]      num_d, num_q;
  logic                    rv_q, rnh_q;
  logic [rsi_pkg::A_W-1:0] ra_q;

  always_comb begin
    hm       = NW'(sq_side.hmag);
    sr       = NW'(sq_root);
    num_d[0] = '0;
    num_d[1] = '0;
    if (!sq_side.gneg && (hm > sr)) begin
      num_d[0] = hm - sr;
    end
    if (!sq_side.gneg) begin
      num_d[1] = hm + sr;
    end else if (sr > hm) begin
      num_d[1] = sr - hm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num_d;
      rnh_q <= sq_side.nohit;
      ra_q  <= sq_side.a;
    end
  end

  logic                                dv_valid, dv_nohit;
  logic [1:0][rsi_pkg::DIST_W-1:0]     dv_dist;

  rsi_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv_q),
    .nohit_i (rnh_q),
    .num_i   (num_q),
    .a_i     (ra_q),
    .valid_o (dv_valid),
    .nohit_o (dv_nohit),
    .dist_o  (dv_dist)
  );

  // The nearer root wins when it clears the minimum distance.
  rsi_pkg::rsi_out_t res;
  logic [rsi_pkg::DIST_W-1:0] min_ext;

  always_comb begin
    min_ext = rsi_pkg::DIST_W'(min_dist_q);
    res     = '0;
    if (!dv_nohit) begin
      if (dv_dist[0] > min_ext) begin
        res.hit          = 1'b1;
        res.hit_distance = dv_dist[0];
      end else if (dv_dist[1] > min_ext) begin
        res.hit          = 1'b1;
        res.hit_distance = dv_dist[1];
        res.far_root     = 1'b1;
      end
    end
  end

  // Two-entry output buffer.
  rsi_pkg::rsi_out_t mem_q [2];
  logic wptr_q, rptr_q;
  logic push, pop;

  assign push = en && dv_valid;
  assign pop  = out_valid_o && out_ready_i;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= res;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rptr_q];

endmodule

// File: rtl/rsi_checker.sv
// Port-level checks for the ray/sphere intersection unit, bound to the top level.
module rsi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rsi_pkg::rsi_out_t out_data_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed or dropped while stalled");

  // A miss carries zero distance and a clear far_root flag.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.hit_distance == '0 && !out_data_o.far_root)
    else $error("miss with nonzero fields");

  // A hit lies strictly beyond a non-negative minimum, so it is never zero.
  a_hit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.hit_distance != '0)
    else $error("hit at zero distance");

  // Input back-pressure only comes from results waiting at the output.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind ray_sphere_intersect_unit rsi_checker u_rsi_checker (.*);
